>>> src/iss_pkg.sv
// Package for the insertion sort stage: word types, codes, controller types and defaults.
package iss_pkg;

   localparam int SLOTS_DEFAULT = 10;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int WORD_WIDTH = 32;

   localparam logic KIND_VALUE = 1'b0;
   localparam logic KIND_END = 1'b1;

   localparam logic [1:0] RK_OVERFLOW = 2'd0;
   localparam logic [1:0] RK_ELEMENT = 2'd1;
   localparam logic [1:0] RK_END = 2'd2;

   typedef struct packed {
      logic kind;
      logic signed [WORD_WIDTH-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic signed [WORD_WIDTH-1:0] result_value;
      logic last;
   } rsp_word_type;

   typedef enum logic {
      ST_IDLE,
      ST_FLUSH
   } iss_state_type;

   typedef struct packed {
      logic insert;
      logic emit_elem;
      logic emit_end;
      logic idx_clr;
   } iss_cmd_type;

   typedef struct packed {
      logic out_free;
      logic elem_avail;
   } iss_status_type;

endpackage

>>> src/iss_chan_if.sv
// Valid/ready channel interface that carries one word per handshake.
interface iss_chan_if #(
   parameter type word_type = logic
);
   logic valid;
   logic ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

>>> src/iss_ctrl.sv
// Controller state machine of the insertion sort stage.
module iss_ctrl
   import iss_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_kind,
   input iss_status_type status,
   output logic req_ready,
   output iss_cmd_type cmd
);

   iss_state_type state_ff;
   iss_state_type state_in;
   logic accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_END) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.out_free && !status.elem_avail) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            cmd.insert = accept && req_kind == KIND_VALUE;
            cmd.idx_clr = accept && req_kind == KIND_END;
         end
         ST_FLUSH: begin
            cmd.emit_elem = status.out_free && status.elem_avail;
            cmd.emit_end = status.out_free && !status.elem_avail;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> src/iss_datapath.sv
// Datapath of the insertion sort stage: sorted slots, flush index and output register.
module iss_datapath
   import iss_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic signed [WORD_WIDTH-1:0] req_value,
   input iss_cmd_type cmd,
   input logic rsp_ready,
   output iss_status_type status,
   output logic rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int CW = $clog2(SLOTS + 1);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [VALUE_WIDTH-1:0] slot_ff [SLOTS];
   logic [VALUE_WIDTH-1:0] slot_in [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] valid_in;
   logic [SLOTS-1:0] gt;
   logic [SLOTS-1:0] take;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] idx_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic [VALUE_WIDTH-1:0] in_val;
   logic [VALUE_WIDTH-1:0] ovf_val;
   logic [VALUE_WIDTH-1:0] sel_val;
   logic [WORD_WIDTH-1:0] sel_word;
   logic full;

   // Stored values are VALUE_WIDTH bits; the channel words are always 32 bits.
   if (VALUE_WIDTH <= WORD_WIDTH) begin : g_narrow
      assign in_val = req_value[VALUE_WIDTH-1:0];
      assign sel_word = {{(WORD_WIDTH - VALUE_WIDTH){1'b0}}, sel_val};
   end else begin : g_wide
      assign in_val = {{(VALUE_WIDTH - WORD_WIDTH){1'b0}}, req_value};
      assign sel_word = sel_val[WORD_WIDTH-1:0];
   end

   assign full = valid_ff[SLOTS-1];

   // Every slot compares against the incoming value at once. Slots above the
   // insertion point take their lower neighbor, the insertion point takes the value.
   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      assign gt[i] = valid_ff[i] && ($signed(slot_ff[i]) > $signed(in_val));
      if (i == 0) begin : g_first
         assign take[i] = gt[i] || !valid_ff[i];
         assign slot_in[i] = take[i] ? in_val : slot_ff[i];
      end else begin : g_rest
         assign take[i] = gt[i] || (!valid_ff[i] && valid_ff[i-1]);
         assign slot_in[i] = !take[i] ? slot_ff[i] : (gt[i-1] ? slot_ff[i-1] : in_val);
      end
   end

   assign ovf_val = gt[SLOTS-1] ? slot_ff[SLOTS-1] : in_val;
   assign sel_val = cmd.emit_elem ? slot_ff[idx_ff[IW-1:0]] : ovf_val;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.insert && !full) begin
         valid_in = (valid_ff << 1) | SLOTS'(1);
      end else if (cmd.emit_end) begin
         valid_in = '0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.emit_elem) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in = rsp_word_ff;
      if (cmd.insert && full) begin
         rsp_valid_in = 1'b1;
         rsp_word_in.result_kind = RK_OVERFLOW;
         rsp_word_in.result_value = sel_word;
         rsp_word_in.last = 1'b1;
      end else if (cmd.emit_elem) begin
         rsp_valid_in = 1'b1;
         rsp_word_in.result_kind = RK_ELEMENT;
         rsp_word_in.result_value = sel_word;
         rsp_word_in.last = 1'b0;
      end else if (cmd.emit_end) begin
         rsp_valid_in = 1'b1;
         rsp_word_in.result_kind = RK_END;
         rsp_word_in.result_value = '0;
         rsp_word_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (cmd.insert) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.elem_avail = (idx_ff < CW'(SLOTS)) && valid_ff[idx_ff[IW-1:0]];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

>>> src/insertion_sort_stage_with_overflow_unit.sv
// Top level of one insertion sort stage with overflow to the next stage.
//
//   Channel   Direction  Word fields                         Purpose
//   req_chan  in         kind, value                         values to insert, end of stream
//   rsp_chan  out        result_kind, result_value, last     overflow, flushed values, end marker
//
// All slots compare and shift in parallel on a value word, so a new value can
// be accepted every cycle while the output register is free. An end word starts
// a flush that walks the stored values one per cycle, while the output register
// is free, through the single output register and then loads the end marker; no
// word is accepted until the end marker is loaded. A result word that waits
// untaken in the output register stalls every input word, even a value that
// makes no result. Synchronous reset empties the store.
module insertion_sort_stage_with_overflow_unit
   import iss_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   iss_chan_if.sink req_chan,
   iss_chan_if.source rsp_chan
);

   iss_cmd_type cmd;
   iss_status_type status;
   req_word_type req_word;
   rsp_word_type rsp_word;

   // The request word is unpacked here so that its kind steers the controller
   // and its value feeds the slot comparators.
   assign req_word = req_chan.word;

   // The controller sequences the flush and gates acceptance on the output
   // register being free or being drained this cycle.
   iss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_word.kind),
      .status    (status),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   // The datapath holds the sorted slots with their valid bits, the flush
   // index and the registered result word.
   iss_datapath #(
      .SLOTS       (SLOTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_word.value),
      .cmd       (cmd),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .rsp_valid (rsp_chan.valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_chan.word = rsp_word;

endmodule
